### rtl/k_extreme_value_tracker_defines.svh
// Assertion macros used by the tracker top level.
`ifndef K_EXTREME_VALUE_TRACKER_DEFINES_SVH
`define K_EXTREME_VALUE_TRACKER_DEFINES_SVH

// Checks that a property holds at every clock edge outside reset.
`define KEVT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle implies a consequence in the next.
`define KEVT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/kevt_pkg.sv
// Package with the widths, codes and cell types of the extreme value tracker.
`default_nettype none
package kevt_pkg;
	localparam int MAX_KEPT   = 16;
	localparam int VALUE_BITS = 32;
	localparam int CNT_W      = 5;
	localparam int RANK_W     = 4;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_READ   = 1'b1;
	localparam logic LIST_LOW   = 1'b0;
	localparam logic LIST_HIGH  = 1'b1;

	typedef logic signed [VALUE_BITS-1:0] val_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [RANK_W-1:0] rank_t;

	// Per-cell control computed by the top level each cycle.
	typedef struct packed {
		logic ins;
		logic full;
		logic used;
		logic win;
		val_t value;
	} cell_ctrl_t;

	// What a cell shows its neighbors.
	typedef struct packed {
		val_t low;
		val_t high;
		logic low_gt;
		logic high_gt;
		logic high_lt;
	} cell_link_t;
endpackage
`default_nettype wire

### rtl/kevt_ifs.sv
// Handshake channel interfaces of the extreme value tracker.
`default_nettype none
interface kevt_req_if;
	logic                valid;
	logic                ready;
	logic                cmd;
	kevt_pkg::val_t      energy;
	kevt_pkg::rank_t     rank;
	logic                which_list;
	modport source (output valid, cmd, energy, rank, which_list, input ready);
	modport sink (input valid, cmd, energy, rank, which_list, output ready);
endinterface

interface kevt_rsp_if;
	logic                valid;
	logic                ready;
	kevt_pkg::val_t      value;
	kevt_pkg::cnt_t      fill_count;
	logic                rank_valid;
	modport source (output valid, value, fill_count, rank_valid, input ready);
	modport sink (input valid, value, fill_count, rank_valid, output ready);
endinterface

interface kevt_cfg_if;
	logic                valid;
	logic                ready;
	kevt_pkg::cnt_t      capacity;
	modport source (output valid, capacity, input ready);
	modport sink (input valid, capacity, output ready);
endinterface
`default_nettype wire

### rtl/kevt_cell.sv
// One compare-and-shift cell holding one rank of the low list and the high list.
`default_nettype none
module kevt_cell (
	input  wire                       clk,
	input  wire kevt_pkg::cell_ctrl_t ctrl,
	input  wire kevt_pkg::cell_link_t left,
	input  wire kevt_pkg::cell_link_t right,
	output kevt_pkg::cell_link_t      link
);
	kevt_pkg::val_t low_q;
	kevt_pkg::val_t high_q;

	// An empty slot counts as larger than any value.
	assign link.low     = low_q;
	assign link.high    = high_q;
	assign link.low_gt  = !ctrl.used || (low_q > ctrl.value);
	assign link.high_gt = !ctrl.used || (high_q > ctrl.value);
	assign link.high_lt = high_q < ctrl.value;

	always_ff @(posedge clk) begin
		if (ctrl.ins && ctrl.win) begin
			if (link.low_gt) begin
				low_q <= left.low_gt ? left.low : ctrl.value;
			end
			if (!ctrl.full) begin
				if (link.high_gt) begin
					high_q <= left.high_gt ? left.high : ctrl.value;
				end
			end else if (link.high_lt) begin
				// Full high list shifts down and drops its smallest entry.
				high_q <= right.high_lt ? right.high : ctrl.value;
			end
		end
	end
endmodule
`default_nettype wire

### rtl/k_extreme_value_tracker.sv
// Top level of the running k-smallest and k-largest value tracker.
// Usage: items arrive as beats on req. An insert beat (cmd 0) offers energy,
// a signed Q16.16 value, to both lists at once; a read beat (cmd 1) returns
// the entry at rank of the list chosen by which_list. Every request beat
// yields exactly one response beat on rsp carrying value, fill_count and
// rank_valid. An insert returns value zero and the new fill count.
// The response beat is valid in the cycle after the request beat.
// Throughput is one beat per cycle while rsp is not stalled, set by the row of
// sixteen compare-and-shift cells, which all update in the same cycle.
// When rsp is stalled the response stays in its register and req.ready
// drops, so at most one result is held. A new request is taken in the same
// cycle the held response is taken.
// The cfg channel writes capacity (1 to 16, larger values act as 16); it is
// always ready but a write only lands while the lists are empty.
// Reset empties both lists, sets capacity to 16 and clears the response
// valid flag. List storage itself is not cleared; unfilled ranks read zero.
`default_nettype none
`include "k_extreme_value_tracker_defines.svh"
module k_extreme_value_tracker (
	input  wire        clk,
	input  wire        arst_n,
	kevt_req_if.sink   req,
	kevt_rsp_if.source rsp,
	kevt_cfg_if.sink   cfg
);
	localparam int N = kevt_pkg::MAX_KEPT;

	kevt_pkg::cnt_t cap_q;
	kevt_pkg::cnt_t kept_q;
	kevt_pkg::cnt_t cap_eff;
	kevt_pkg::cnt_t kept_nxt;
	logic           full;
	logic           accept;
	logic           do_insert;
	logic           do_read;
	logic           grow;

	logic           out_valid_q;
	kevt_pkg::val_t value_q;
	kevt_pkg::cnt_t fill_q;
	logic           rank_valid_q;

	kevt_pkg::cell_ctrl_t ctrl [N];
	kevt_pkg::cell_link_t link [N];
	kevt_pkg::cell_link_t left [N];
	kevt_pkg::cell_link_t right [N];

	kevt_pkg::val_t rd_value;
	logic           rd_hit;

	// Capacity above the list depth acts as the full depth.
	assign cap_eff = (cap_q > kevt_pkg::cnt_t'(N)) ? kevt_pkg::cnt_t'(N) : cap_q;
	assign full    = kept_q >= cap_eff;

	// A response register separates the two sides; a new beat enters as the
	// held one leaves.
	assign req.ready = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign do_insert = accept && (req.cmd == kevt_pkg::CMD_INSERT);
	assign do_read   = accept && (req.cmd == kevt_pkg::CMD_READ);
	assign grow      = do_insert && !full;
	assign kept_nxt  = grow ? kept_q + kevt_pkg::cnt_t'(1) : kept_q;

	assign cfg.ready = 1'b1;

	// Build the row of cells. Each cell sees its left neighbor for inserts that
	// shift up and its right neighbor for the full high list shifting down.
	for (genvar i = 0; i < N; i++) begin : g_cell
		assign ctrl[i].ins   = do_insert;
		assign ctrl[i].full  = full;
		assign ctrl[i].used  = kevt_pkg::cnt_t'(i) < kept_q;
		assign ctrl[i].win   = kevt_pkg::cnt_t'(i) < cap_eff;
		assign ctrl[i].value = req.energy;

		if (i == 0) begin : g_first
			assign left[i] = '0;
		end else begin : g_mid
			assign left[i] = link[i-1];
		end

		if (i == N - 1) begin : g_last
			assign right[i] = '0;
		end else begin : g_inner
			// Beyond the last kept rank there is nothing to pull down.
			always_comb begin
				right[i]         = link[i+1];
				right[i].high_lt = link[i+1].high_lt && ctrl[i+1].win;
			end
		end

		kevt_cell u_cell (
			.clk   (clk),
			.ctrl  (ctrl[i]),
			.left  (left[i]),
			.right (right[i]),
			.link  (link[i])
		);
	end

	// Read path: one rank of either list, zero when the rank is not filled.
	assign rd_hit   = kevt_pkg::cnt_t'(req.rank) < kept_q;
	assign rd_value = (req.which_list == kevt_pkg::LIST_HIGH) ?
		link[req.rank].high : link[req.rank].low;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= kevt_pkg::cnt_t'(N);
			kept_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready && (kept_q == '0)) begin
				cap_q <= cfg.capacity;
			end
			kept_q <= kept_nxt;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fill_q <= kept_nxt;
			if (req.cmd == kevt_pkg::CMD_READ && rd_hit) begin
				value_q      <= rd_value;
				rank_valid_q <= 1'b1;
			end else begin
				value_q      <= '0;
				rank_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.value      = value_q;
	assign rsp.fill_count = fill_q;
	assign rsp.rank_valid = rank_valid_q;

	`KEVT_ASSERT(a_kept_within_cap, kept_q <= cap_eff, "fill count exceeds capacity")
	`KEVT_ASSERT_NEXT(a_insert_grows, grow, kept_q > $past(kept_q), "insert did not grow the lists")
	`KEVT_ASSERT_NEXT(a_read_stable, do_read, out_valid_q && $stable(kept_q), "read changed state")
endmodule
`default_nettype wire
